// ===== hw/rtl/pts_pkg.sv =====
// Shared types and codes for the pulse train sequencer.
// No dependencies; imported by pts_engine and pulse_train_sequencer_core.
`default_nettype none

package pts_pkg;

    localparam int unsigned TimeWidth  = 32;
    localparam int unsigned TickWidth  = 16;
    localparam int unsigned CountWidth = 16;
    localparam int unsigned CfgIdxWidth = 2;

    // Phase codes as reported on the result channel.
    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_ON   = 2'd1,
        PH_GAP  = 2'd2,
        PH_OFF  = 2'd3
    } phase_t;

    // Action codes of an input transaction. Code 3 is unused and ignored.
    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_START = 2'd1,
        ACT_STOP  = 2'd2
    } action_t;

    // Configuration register indexes.
    typedef enum logic [CfgIdxWidth-1:0] {
        REG_START_DELAY  = 2'd0,
        REG_PULSE_WIDTH  = 2'd1,
        REG_PULSE_PERIOD = 2'd2,
        REG_PULSE_COUNT  = 2'd3
    } cfg_index_t;

    // One result transaction.
    typedef struct packed {
        phase_t                 phase;
        logic                   changed;
        logic                   turn_on;
        logic                   turn_off;
        logic [TimeWidth-1:0]   lateness;
        logic [CountWidth-1:0]  pulses_left;
    } pts_result_t;

    // Active timing configuration handed to the engine.
    typedef struct packed {
        logic [TimeWidth-1:0]   start_delay;
        logic [TimeWidth-1:0]   pulse_width;
        logic [TimeWidth-1:0]   gap_thr;
        logic [CountWidth-1:0]  pulse_count;
    } pts_cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pulse_train_sequencer_core.sv =====
// Top level of the pulse train sequencer: handshakes, configuration registers
// and the input and result registers. Depends on pts_pkg and pts_engine.
`default_nettype none

// The sequencer takes one transaction per clock cycle on the s_ channel while
// s_ready is high and returns exactly one result for each on the m_ channel,
// in order. A transaction is held in an input register and updates the
// sequencer state as it moves into the result register, once that is free.
// The input and result registers are the only buffering: while the result
// waits for m_ready the input register still takes one more transaction, and
// s_ready falls only when both are full. Configuration writes are always ready
// and must be made only while no transaction is in flight; the gap threshold
// is a register fed from the period and width registers.
module pulse_train_sequencer_core
    import pts_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,

    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [1:0]              s_action,
    input  wire logic [TickWidth-1:0]    s_ticks,

    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic [1:0]                   m_phase,
    output logic                         m_changed,
    output logic                         m_turn_on,
    output logic                         m_turn_off,
    output logic [TimeWidth-1:0]         m_lateness,
    output logic [CountWidth-1:0]        m_pulses_left,

    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CfgIdxWidth-1:0]  cfg_index,
    input  wire logic [TimeWidth-1:0]    cfg_data
);

    logic [TimeWidth-1:0]   start_delay_reg;
    logic [TimeWidth-1:0]   pulse_width_reg;
    logic [TimeWidth-1:0]   pulse_period_reg;
    logic [CountWidth-1:0]  pulse_count_reg;
    logic [TimeWidth-1:0]   gap_thr_reg, gap_thr_next;

    logic                   in_valid_reg;
    logic [1:0]             in_action_reg;
    logic [TickWidth-1:0]   in_ticks_reg;

    logic                   out_valid_reg;
    pts_result_t            out_reg;

    logic                   advance;
    pts_cfg_t               cfg;
    pts_result_t            step_result;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_delay_reg  <= '0;
            pulse_width_reg  <= '0;
            pulse_period_reg <= '0;
            pulse_count_reg  <= CountWidth'(1);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_START_DELAY:  start_delay_reg  <= cfg_data;
                REG_PULSE_WIDTH:  pulse_width_reg  <= cfg_data;
                REG_PULSE_PERIOD: pulse_period_reg <= cfg_data;
                REG_PULSE_COUNT:  pulse_count_reg  <= cfg_data[CountWidth-1:0];
                default: begin
                end
            endcase
        end
    end

    // Gap length, zero when the period is shorter than the pulse.
    assign gap_thr_next = (pulse_period_reg >= pulse_width_reg)
                        ? pulse_period_reg - pulse_width_reg : '0;

    always_ff @(posedge aclk) begin
        gap_thr_reg <= gap_thr_next;
    end

    assign cfg.start_delay = start_delay_reg;
    assign cfg.pulse_width = pulse_width_reg;
    assign cfg.gap_thr     = gap_thr_reg;
    assign cfg.pulse_count = pulse_count_reg;

    // Pipeline control: the held transaction moves on when the result slot frees.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_action_reg <= s_action;
            in_ticks_reg  <= s_ticks;
        end
    end

    pts_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .action  (in_action_reg),
        .ticks   (in_ticks_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= step_result;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_phase       = out_reg.phase;
    assign m_changed     = out_reg.changed;
    assign m_turn_on     = out_reg.turn_on;
    assign m_turn_off    = out_reg.turn_off;
    assign m_lateness    = out_reg.lateness;
    assign m_pulses_left = out_reg.pulses_left;

endmodule

`default_nettype wire

// ===== hw/rtl/pts_engine.sv =====
// Sequencer state (phase, elapsed counter, pulse counter) and its one-step update.
// Depends on pts_pkg.
`default_nettype none

module pts_engine
    import pts_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  step_en,
    input  wire logic [1:0]            action,
    input  wire logic [TickWidth-1:0]  ticks,
    input  wire pts_cfg_t              cfg,
    output pts_result_t                result
);

    phase_t                 phase_reg, phase_next;
    logic [TimeWidth-1:0]   elapsed_reg, elapsed_next;
    logic [CountWidth-1:0]  remaining_reg, remaining_next;
    logic                   endless_reg, endless_next;

    logic [TimeWidth:0]     sum;
    logic [TimeWidth-1:0]   elapsed_sat;
    logic [TimeWidth-1:0]   thr;
    logic [TimeWidth:0]     diff;
    logic                   reached;
    logic [CountWidth-1:0]  rem_dec;
    logic                   on_ev;
    logic                   off_ev;
    logic [TimeWidth-1:0]   late;

    // Saturating accumulation of the tick count.
    assign sum         = {1'b0, elapsed_reg} + {{(TimeWidth-TickWidth+1){1'b0}}, ticks};
    assign elapsed_sat = sum[TimeWidth] ? {TimeWidth{1'b1}} : sum[TimeWidth-1:0];

    // Threshold of the current phase; the off phase never transitions.
    always_comb begin
        case (phase_reg)
            PH_WAIT: thr = cfg.start_delay;
            PH_ON:   thr = cfg.pulse_width;
            PH_GAP:  thr = cfg.gap_thr;
            default: thr = {TimeWidth{1'b1}};
        endcase
    end

    // One subtraction gives both the compare and the lateness.
    assign diff    = {1'b0, elapsed_sat} - {1'b0, thr};
    assign reached = !diff[TimeWidth] && (phase_reg != PH_OFF);
    assign rem_dec = (remaining_reg != '0) ? remaining_reg - 1'b1 : remaining_reg;

    // Next state for one transaction.
    always_comb begin
        phase_next     = phase_reg;
        elapsed_next   = elapsed_reg;
        remaining_next = remaining_reg;
        endless_next   = endless_reg;
        on_ev          = 1'b0;
        off_ev         = 1'b0;
        late           = '0;
        case (action)
            ACT_START: begin
                elapsed_next = '0;
                phase_next   = PH_WAIT;
            end
            ACT_STOP: begin
                phase_next = PH_OFF;
            end
            ACT_TICK: begin
                elapsed_next = elapsed_sat;
                if (reached) begin
                    elapsed_next = '0;
                    late         = diff[TimeWidth-1:0];
                    case (phase_reg)
                        PH_WAIT: begin
                            remaining_next = cfg.pulse_count;
                            endless_next   = (cfg.pulse_count == '0);
                            phase_next     = PH_ON;
                            on_ev          = 1'b1;
                        end
                        PH_ON: begin
                            off_ev     = 1'b1;
                            phase_next = PH_GAP;
                            if (!endless_reg) begin
                                remaining_next = rem_dec;
                                if (rem_dec == '0) begin
                                    phase_next = PH_OFF;
                                end
                            end
                        end
                        default: begin
                            phase_next = PH_ON;
                            on_ev      = 1'b1;
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    // Result of this transaction, registered by the caller.
    always_comb begin
        result.phase       = phase_next;
        result.changed     = (phase_next != phase_reg);
        result.turn_on     = on_ev;
        result.turn_off    = off_ev;
        result.lateness    = late;
        result.pulses_left = endless_next ? '0 : remaining_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_WAIT;
            elapsed_reg   <= '0;
            remaining_reg <= '0;
            endless_reg   <= 1'b0;
        end else if (step_en) begin
            phase_reg     <= phase_next;
            elapsed_reg   <= elapsed_next;
            remaining_reg <= remaining_next;
            endless_reg   <= endless_next;
        end
    end

endmodule

`default_nettype wire

// ===== sim/pulse_train_sequencer_core_tb.sv =====
// Self-checking testbench for the pulse train sequencer core.
// Depends on pts_pkg and pulse_train_sequencer_core; predicts every result in-line.
`default_nettype none

module pulse_train_sequencer_core_tb;
    import pts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Action code 3 is left out of the package enum; the block ignores it.
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int unsigned MaxPrinted = 40;

    typedef struct packed {
        logic [1:0]           action;
        logic [TickWidth-1:0] ticks;
    } train_cmd_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [1:0]             s_action = ACT_TICK;
    logic [TickWidth-1:0]   s_ticks = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [1:0]             m_phase;
    logic                   m_changed;
    logic                   m_turn_on;
    logic                   m_turn_off;
    logic [TimeWidth-1:0]   m_lateness;
    logic [CountWidth-1:0]  m_pulses_left;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CfgIdxWidth-1:0] cfg_index = REG_START_DELAY;
    logic [TimeWidth-1:0]   cfg_data = '0;

    pulse_train_sequencer_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_ticks       (s_ticks),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_phase       (m_phase),
        .m_changed     (m_changed),
        .m_turn_on     (m_turn_on),
        .m_turn_off    (m_turn_off),
        .m_lateness    (m_lateness),
        .m_pulses_left (m_pulses_left),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Commands waiting to be sent and results still owed by the block.
    train_cmd_t  cmd_queue[$];
    pts_result_t train_expect[$];

    int unsigned mismatches = 0;
    int unsigned results_seen = 0;
    int unsigned send_gap = 0;
    int unsigned recv_stall = 0;
    logic        s_took = 1'b0;
    logic        quiet = 1'b0;

    // Predicted sequencer state and the register settings it runs on.
    phase_t                 seq_phase = PH_WAIT;
    logic [TimeWidth-1:0]   seq_elapsed = '0;
    logic [CountWidth-1:0]  seq_left = '0;
    logic                   seq_endless = 1'b0;
    logic [TimeWidth-1:0]   set_delay = '0;
    logic [TimeWidth-1:0]   set_width = '0;
    logic [TimeWidth-1:0]   set_period = '0;
    logic [CountWidth-1:0]  set_count = 16'd1;

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #(20_000_000);
        $display("pulse_train_sequencer_core_tb NOT OK");
        $finish;
    end

    // Apply one command to the predicted state and return the result it yields.
    function automatic pts_result_t advance_train(input logic [1:0] act,
                                                  input logic [TickWidth-1:0] tk);
        pts_result_t          res;
        phase_t               was;
        logic [TimeWidth:0]   sum;
        logic [TimeWidth-1:0] gap_thr;
        res = '0;
        was = seq_phase;
        case (act)
            ACT_START: begin
                seq_elapsed = '0;
                seq_phase = PH_WAIT;
            end
            ACT_STOP: begin
                seq_phase = PH_OFF;
            end
            ACT_TICK: begin
                // Elapsed time saturates instead of wrapping.
                sum = {1'b0, seq_elapsed} + {{(TimeWidth + 1 - TickWidth){1'b0}}, tk};
                seq_elapsed = sum[TimeWidth] ? '1 : sum[TimeWidth-1:0];
                gap_thr = (set_period >= set_width) ? set_period - set_width : '0;
                case (seq_phase)
                    PH_WAIT: begin
                        if (seq_elapsed >= set_delay) begin
                            seq_left = set_count;
                            seq_endless = (set_count == '0);
                            seq_phase = PH_ON;
                            res.turn_on = 1'b1;
                            res.lateness = seq_elapsed - set_delay;
                            seq_elapsed = '0;
                        end
                    end
                    PH_ON: begin
                        if (seq_elapsed >= set_width) begin
                            seq_phase = PH_GAP;
                            if (!seq_endless) begin
                                if (seq_left != '0) seq_left = seq_left - 1'b1;
                                if (seq_left == '0) seq_phase = PH_OFF;
                            end
                            res.turn_off = 1'b1;
                            res.lateness = seq_elapsed - set_width;
                            seq_elapsed = '0;
                        end
                    end
                    PH_GAP: begin
                        if (seq_elapsed >= gap_thr) begin
                            seq_phase = PH_ON;
                            res.turn_on = 1'b1;
                            res.lateness = seq_elapsed - gap_thr;
                            seq_elapsed = '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
        res.phase = seq_phase;
        res.changed = (seq_phase != was);
        res.pulses_left = seq_endless ? '0 : seq_left;
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MaxPrinted)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got 0x%0h want 0x%0h",
                                      results_seen, name, got, want));
    endtask

    // Sender: presents queued commands at the falling edge, with idle bursts.
    always @(negedge aclk) begin : drive_cmds
        train_cmd_t cmd;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_took) begin
            if (send_gap > 0 && !quiet) begin
                send_gap <= send_gap - 1;
                s_valid <= 1'b0;
            end else if (cmd_queue.size() > 0 && !quiet && $urandom_range(0, 7) == 0) begin
                send_gap <= $urandom_range(0, 17);
                s_valid <= 1'b0;
            end else if (cmd_queue.size() > 0) begin
                cmd = cmd_queue.pop_front();
                s_valid <= 1'b1;
                s_action <= cmd.action;
                s_ticks <= cmd.ticks;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: stalls the result channel in random bursts.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (quiet) begin
            m_ready <= 1'b1;
        end else if (recv_stall > 0) begin
            recv_stall <= recv_stall - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
            recv_stall <= $urandom_range(0, 17);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Monitor: checks each result transaction and predicts each accepted command.
    always @(posedge aclk) begin : watch_results
        pts_result_t want;
        s_took <= aresetn && s_valid && s_ready;
        if (aresetn && m_valid && m_ready) begin
            if (train_expect.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with none expected",
                                          results_seen));
            end else begin
                want = train_expect.pop_front();
                check_field("phase", 32'(m_phase), 32'(want.phase));
                check_field("changed", 32'(m_changed), 32'(want.changed));
                check_field("turn_on", 32'(m_turn_on), 32'(want.turn_on));
                check_field("turn_off", 32'(m_turn_off), 32'(want.turn_off));
                check_field("lateness", m_lateness, want.lateness);
                check_field("pulses_left", 32'(m_pulses_left), 32'(want.pulses_left));
            end
            results_seen++;
        end
        if (aresetn && s_valid && s_ready)
            train_expect.push_back(advance_train(s_action, s_ticks));
    end

    task automatic push_cmd(input logic [1:0] act, input logic [TickWidth-1:0] tk);
        train_cmd_t cmd;
        cmd.action = act;
        cmd.ticks = tk;
        cmd_queue.push_back(cmd);
    endtask

    // Write one register and mirror it once the write transaction is taken.
    task automatic write_reg(input cfg_index_t idx, input logic [TimeWidth-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_START_DELAY:  set_delay = data;
            REG_PULSE_WIDTH:  set_width = data;
            REG_PULSE_PERIOD: set_period = data;
            REG_PULSE_COUNT:  set_count = data[CountWidth-1:0];
            default: begin
            end
        endcase
    endtask

    task automatic program_train(input logic [31:0] delay, input logic [31:0] width,
                                 input logic [31:0] period, input logic [31:0] count_word);
        write_reg(REG_START_DELAY, delay);
        write_reg(REG_PULSE_WIDTH, width);
        write_reg(REG_PULSE_PERIOD, period);
        write_reg(REG_PULSE_COUNT, count_word);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Block until the sender is empty and every result has come back.
    task automatic wait_drained();
        while (cmd_queue.size() != 0 || s_valid || train_expect.size() != 0)
            @(posedge aclk);
    endtask

    // Mostly small timings so trains run through all phases, plus extremes.
    function automatic logic [31:0] rand_timing();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom();
            3: return 32'($urandom_range(0, 65535));
            default: return 32'($urandom_range(0, 40));
        endcase
    endfunction

    function automatic logic [31:0] rand_count_word();
        case ($urandom_range(0, 9))
            0, 1: return '0;
            2: return 32'h0000_FFFF;
            3, 4: return $urandom();
            default: return 32'($urandom_range(1, 4));
        endcase
    endfunction

    function automatic logic [TickWidth-1:0] rand_ticks();
        case ($urandom_range(0, 15))
            0: return '0;
            1: return '1;
            2, 3: return TickWidth'($urandom());
            default: return TickWidth'($urandom_range(0, 12));
        endcase
    endfunction

    initial begin : stimulus
        int unsigned sent;
        int unsigned n;
        int unsigned pick;
        sent = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Short train straight out of reset, without a start command.
        program_train(32'd3, 32'd2, 32'd5, 32'd2);
        push_cmd(ACT_TICK, 16'd1);
        push_cmd(ACT_TICK, 16'd2);
        push_cmd(ACT_TICK, 16'd0);
        push_cmd(ACT_TICK, 16'd5);
        push_cmd(ACT_TICK, 16'd3);
        push_cmd(ACT_TICK, 16'd2);
        push_cmd(ACT_TICK, 16'd7);
        push_cmd(ACT_STOP, 16'h5A5A);
        push_cmd(ACT_UNUSED, 16'hFFFF);
        push_cmd(ACT_START, 16'hA5A5);
        push_cmd(ACT_TICK, 16'hFFFF);
        push_cmd(ACT_STOP, 16'd0);
        wait_drained();

        // Endless train with a period shorter than the width; count upper bits ignored.
        program_train(32'd0, 32'd10, 32'd4, 32'hABCD_0000);
        push_cmd(ACT_START, 16'd0);
        push_cmd(ACT_TICK, 16'd0);
        push_cmd(ACT_TICK, 16'd10);
        push_cmd(ACT_TICK, 16'd0);
        push_cmd(ACT_TICK, 16'd12);
        push_cmd(ACT_TICK, 16'd0);
        push_cmd(ACT_STOP, 16'd0);
        wait_drained();

        // All-ones delay and width, a zero period and the largest pulse count.
        program_train(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'h0000_FFFF);
        push_cmd(ACT_START, 16'd0);
        push_cmd(ACT_TICK, 16'hFFFF);
        push_cmd(ACT_TICK, 16'd0);
        wait_drained();

        // Random phases: new settings each time, mostly well-formed trains with noise.
        while (sent < 1600) begin
            program_train(rand_timing(), rand_timing(), rand_timing(), rand_count_word());
            if ($urandom_range(0, 99) < 85) begin
                push_cmd(ACT_START, rand_ticks());
                sent++;
            end
            n = $urandom_range(60, 140);
            repeat (n) begin
                pick = $urandom_range(0, 99);
                if (pick < 88) begin
                    push_cmd(ACT_TICK, rand_ticks());
                    sent++;
                end else if (pick < 93) begin
                    push_cmd(ACT_START, TickWidth'($urandom()));
                    sent++;
                end else if (pick < 97) begin
                    push_cmd(ACT_STOP, TickWidth'($urandom()));
                    sent++;
                end else begin
                    push_cmd(ACT_UNUSED, TickWidth'($urandom()));
                end
            end
            wait_drained();
        end

        // Final stretch with no idling: a short endless train sent back to back.
        quiet = 1'b1;
        program_train(32'd20, 32'd3, 32'd5, 32'd0);
        push_cmd(ACT_START, 16'd0);
        repeat (40) push_cmd(ACT_TICK, TickWidth'($urandom_range(0, 6)));
        wait_drained();

        // Give any stray result time to show up.
        repeat (10) @(posedge aclk);
        if (mismatches == 0)
            $display("pulse_train_sequencer_core_tb OK");
        else
            $display("pulse_train_sequencer_core_tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
